>>> rtl/core/block_average_pixelate_defines.svh
// Assertion macros shared by the pixelation block.
`ifndef BLOCK_AVERAGE_PIXELATE_DEFINES_SVH
`define BLOCK_AVERAGE_PIXELATE_DEFINES_SVH
`define BAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/bap_pkg.sv
// Package with types and constants of the pixelation block.
`timescale 1ns / 1ps
package bap_pkg;
   localparam int MaxWidth = 4096;
   localparam int MaxBlock = 64;
   localparam int MaxHeight = 4096;
   localparam int SumW = 20;
   localparam int ColW = 12;
   localparam int CntW = 13;
   localparam logic [1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_ADD, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic read;
      logic add;
      logic div_start;
      logic out_valid;
   } cmd_type;

   typedef struct packed {
      logic finish;
      logic div_done;
   } sts_type;
endpackage

>>> rtl/core/bap_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bap_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/core/bap_ctrl.sv
// Controller state machine of the pixelation block.
`timescale 1ns / 1ps
module bap_ctrl import bap_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output logic    req_ready,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_READ;
         ST_READ: state_in = ST_ADD;
         ST_ADD: state_in = sts.finish ? ST_DIV : ST_IDLE;
         ST_DIV: if (sts.div_done) state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
         end
         ST_READ: cmd.read = 1'b1;
         ST_ADD: begin
            cmd.add = 1'b1;
            cmd.div_start = sts.finish;
         end
         ST_OUT: cmd.out_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

>>> rtl/core/bap_dp.sv
// Datapath: position counters, column sums and serial divider.
`timescale 1ns / 1ps
module bap_dp import bap_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_write_data,
   input  logic [7:0]    req_red,
   input  logic [7:0]    req_green,
   input  logic [7:0]    req_blue,
   output logic [11:0]   rsp_block_col,
   output logic [11:0]   rsp_block_row,
   output logic [6:0]    rsp_span_x,
   output logic [6:0]    rsp_span_y,
   output logic [7:0]    rsp_red_mean,
   output logic [7:0]    rsp_green_mean,
   output logic [7:0]    rsp_blue_mean,
   output logic          rsp_frame_end
);
   logic [6:0] bs_reg_ff;
   logic [12:0] w_reg_ff, h_reg_ff;
   logic [6:0] bs;
   logic [12:0] w, h;
   logic [11:0] px_ff, py_ff, bx_ff, by_ff;
   logic [5:0] ox_ff, oy_ff;
   logic [7:0] r_ff, g_ff, b_ff;
   logic [SumW-1:0] rs_rd, gs_rd, bs_rd, rs_new, gs_new, bs_new;
   logic [12:0] remx, remy;
   logic [6:0] sx, sy;
   logic finish;
   logic fe;
   logic restart;
   logic [6:0] sx_ff, sy_ff;
   logic [11:0] ocol_ff, orow_ff;
   logic fe_ff;
   logic [CntW-1:0] cnt_ff;
   logic [4:0] step_ff;
   logic busy_ff;
   logic [SumW-1:0] qr_ff, qg_ff, qb_ff;
   logic [CntW:0] ar_ff, ag_ff, ab_ff;
   logic [CntW:0] tr, tg, tb;
   logic [12:0] px1;
   logic [6:0] ox1, oy1;
   logic [12:0] py1;

   assign bs = (bs_reg_ff == 7'd0) ? 7'd1 : (bs_reg_ff > 7'd64) ? 7'd64 : bs_reg_ff;
   assign w = (w_reg_ff == 13'd0) ? 13'd1 : (w_reg_ff > 13'd4096) ? 13'd4096 : w_reg_ff;
   assign h = (h_reg_ff == 13'd0) ? 13'd1 : (h_reg_ff > 13'd4096) ? 13'd4096 : h_reg_ff;

   assign restart = csr_write_enable && (csr_index == CSR_BLOCK_SIZE ||
      csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_reg_ff <= 7'd10;
         w_reg_ff <= 13'd640;
         h_reg_ff <= 13'd480;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: bs_reg_ff <= csr_write_data[6:0];
            CSR_IMAGE_WIDTH: w_reg_ff <= csr_write_data;
            CSR_IMAGE_HEIGHT: h_reg_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         r_ff <= req_red;
         g_ff <= req_green;
         b_ff <= req_blue;
      end
   end

   bap_ram #(.Width(SumW), .Depth(MaxWidth)) u_red (.clock(clock), .we(cmd.add),
      .addr(bx_ff), .wdata(rs_new), .rdata(rs_rd));
   bap_ram #(.Width(SumW), .Depth(MaxWidth)) u_green (.clock(clock), .we(cmd.add),
      .addr(bx_ff), .wdata(gs_new), .rdata(gs_rd));
   bap_ram #(.Width(SumW), .Depth(MaxWidth)) u_blue (.clock(clock), .we(cmd.add),
      .addr(bx_ff), .wdata(bs_new), .rdata(bs_rd));

   always_comb begin
      if (ox_ff == 6'd0 && oy_ff == 6'd0) begin
         rs_new = {12'd0, r_ff};
         gs_new = {12'd0, g_ff};
         bs_new = {12'd0, b_ff};
      end else begin
         rs_new = rs_rd + {12'd0, r_ff};
         gs_new = gs_rd + {12'd0, g_ff};
         bs_new = bs_rd + {12'd0, b_ff};
      end
   end

   assign remx = w - ({1'b0, px_ff} - {7'd0, ox_ff});
   assign remy = h - ({1'b0, py_ff} - {7'd0, oy_ff});
   assign sx = (remx < {6'd0, bs}) ? remx[6:0] : bs;
   assign sy = (remy < {6'd0, bs}) ? remy[6:0] : bs;
   assign ox1 = {1'b0, ox_ff} + 7'd1;
   assign oy1 = {1'b0, oy_ff} + 7'd1;
   assign px1 = {1'b0, px_ff} + 13'd1;
   assign py1 = {1'b0, py_ff} + 13'd1;
   assign finish = (ox1 == sx) && (oy1 == sy);
   assign fe = (px1 == w) && (py1 == h);
   assign sts.finish = finish;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         px_ff <= '0; py_ff <= '0; ox_ff <= '0; oy_ff <= '0; bx_ff <= '0; by_ff <= '0;
      end else if (cmd.add) begin
         if (px1 >= w) begin
            px_ff <= '0; ox_ff <= '0; bx_ff <= '0;
            if (py1 >= h) begin
               py_ff <= '0; oy_ff <= '0; by_ff <= '0;
            end else begin
               py_ff <= py1[11:0];
               if (oy1 >= bs) begin
                  oy_ff <= '0; by_ff <= by_ff + 12'd1;
               end else begin
                  oy_ff <= oy1[5:0];
               end
            end
         end else begin
            px_ff <= px1[11:0];
            if (ox1 >= bs) begin
               ox_ff <= '0; bx_ff <= bx_ff + 12'd1;
            end else begin
               ox_ff <= ox1[5:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && finish) begin
         sx_ff <= sx; sy_ff <= sy; ocol_ff <= bx_ff; orow_ff <= by_ff; fe_ff <= fe;
         cnt_ff <= CntW'(sx * sy);
      end
   end

   // restoring division, one quotient bit per cycle
   assign tr = {ar_ff[CntW-1:0], qr_ff[SumW-1]} - {1'b0, cnt_ff};
   assign tg = {ag_ff[CntW-1:0], qg_ff[SumW-1]} - {1'b0, cnt_ff};
   assign tb = {ab_ff[CntW-1:0], qb_ff[SumW-1]} - {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 5'd1;
         if (step_ff == 5'(SumW - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         qr_ff <= rs_new; qg_ff <= gs_new; qb_ff <= bs_new;
         ar_ff <= '0; ag_ff <= '0; ab_ff <= '0;
      end else if (busy_ff) begin
         if (!tr[CntW]) begin
            ar_ff <= tr; qr_ff <= {qr_ff[SumW-2:0], 1'b1};
         end else begin
            ar_ff <= {ar_ff[CntW-1:0], qr_ff[SumW-1]}; qr_ff <= {qr_ff[SumW-2:0], 1'b0};
         end
         if (!tg[CntW]) begin
            ag_ff <= tg; qg_ff <= {qg_ff[SumW-2:0], 1'b1};
         end else begin
            ag_ff <= {ag_ff[CntW-1:0], qg_ff[SumW-1]}; qg_ff <= {qg_ff[SumW-2:0], 1'b0};
         end
         if (!tb[CntW]) begin
            ab_ff <= tb; qb_ff <= {qb_ff[SumW-2:0], 1'b1};
         end else begin
            ab_ff <= {ab_ff[CntW-1:0], qb_ff[SumW-1]}; qb_ff <= {qb_ff[SumW-2:0], 1'b0};
         end
      end
   end

   assign sts.div_done = busy_ff && (step_ff == 5'(SumW - 1));

   assign rsp_block_col = ocol_ff;
   assign rsp_block_row = orow_ff;
   assign rsp_span_x = sx_ff;
   assign rsp_span_y = sy_ff;
   assign rsp_red_mean = qr_ff[7:0];
   assign rsp_green_mean = qg_ff[7:0];
   assign rsp_blue_mean = qb_ff[7:0];
   assign rsp_frame_end = fe_ff;
endmodule

>>> rtl/core/block_average_pixelate.sv
// Top level of the block-average pixelation block.
// Pixels enter in raster order on req_ (valid/ready); each block's averages
// leave on rsp_ (valid/ready) when its bottom-right pixel has been taken.
// A pixel that closes no block passes through accept, sum read and sum write
// into the per-column RAMs. A closing pixel adds a restoring divider that
// forms the three means in parallel, then the beat waits in the output stage
// until rsp_ready; no new pixel is taken meanwhile, so a stalled receiver
// holds the input side.
// Configuration writes on csr_ set block size, width or height and restart
// the frame at its top-left pixel. Reset restores 10, 640 and 480 and clears
// the position; the sum RAMs need no clearing since the first pixel of each
// block overwrites its column entry.
`timescale 1ns / 1ps
`include "block_average_pixelate_defines.svh"
module block_average_pixelate import bap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_block_col,
   output logic [11:0] rsp_block_row,
   output logic [6:0]  rsp_span_x,
   output logic [6:0]  rsp_span_y,
   output logic [7:0]  rsp_red_mean,
   output logic [7:0]  rsp_green_mean,
   output logic [7:0]  rsp_blue_mean,
   output logic        rsp_frame_end
);
   cmd_type cmd;
   sts_type sts;

   bap_ctrl u_ctrl (.clock(clock), .reset(reset), .req_valid(req_valid),
      .rsp_ready(rsp_ready), .sts(sts), .req_ready(req_ready), .cmd(cmd));

   bap_dp u_dp (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .req_red(req_red), .req_green(req_green),
      .req_blue(req_blue), .rsp_block_col(rsp_block_col),
      .rsp_block_row(rsp_block_row), .rsp_span_x(rsp_span_x),
      .rsp_span_y(rsp_span_y), .rsp_red_mean(rsp_red_mean),
      .rsp_green_mean(rsp_green_mean), .rsp_blue_mean(rsp_blue_mean),
      .rsp_frame_end(rsp_frame_end));

   assign rsp_valid = cmd.out_valid;

   `BAP_ASSERT_IMPL(a_no_take_while_out, clock, reset, rsp_valid, !req_ready)
   `BAP_ASSERT_NEXT(a_take_then_read, clock, reset, req_valid && req_ready, cmd.read)
   `BAP_ASSERT_IMPL(a_span_nonzero, clock, reset, rsp_valid,
      rsp_span_x != 7'd0 && rsp_span_y != 7'd0)
endmodule

>>> dv/tb.sv
// Self-checking testbench for block_average_pixelate: predicts block means and compares each beat.
`timescale 1ns / 1ps
module tb;
   import bap_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [11:0] block_col;
      logic [11:0] block_row;
      logic [6:0]  span_x;
      logic [6:0]  span_y;
      logic [7:0]  red_mean;
      logic [7:0]  green_mean;
      logic [7:0]  blue_mean;
      logic        frame_end;
   } block_mean_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_block_col;
   logic [11:0] rsp_block_row;
   logic [6:0]  rsp_span_x;
   logic [6:0]  rsp_span_y;
   logic [7:0]  rsp_red_mean;
   logic [7:0]  rsp_green_mean;
   logic [7:0]  rsp_blue_mean;
   logic        rsp_frame_end;

   block_average_pixelate dut (.*);

   always #4 clock = ~clock;

   // predictor state
   int unsigned red_acc[MaxWidth];
   int unsigned green_acc[MaxWidth];
   int unsigned blue_acc[MaxWidth];
   int unsigned pos_x, pos_y, off_x, off_y, blk_x, blk_y;
   int unsigned cfg_block = 10, cfg_width = 640, cfg_height = 480;
   block_mean_type pending_means[$];

   int errors = 0;
   int pixels_sent = 0;
   int burst_left = 0;
   bit steady_send = 0;
   int idle_count = 0;
   int ready_mode = 0;

   function automatic int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_position();
      pos_x = 0; pos_y = 0; off_x = 0; off_y = 0; blk_x = 0; blk_y = 0;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [12:0] data);
      case (idx)
         CSR_BLOCK_SIZE: begin cfg_block = data[6:0]; restart_position(); end
         CSR_IMAGE_WIDTH: begin cfg_width = data; restart_position(); end
         CSR_IMAGE_HEIGHT: begin cfg_height = data; restart_position(); end
         default: ;
      endcase
   endfunction

   function automatic void accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned bs, w, h, col, sx, sy, cnt;
      block_mean_type m;
      bs = clip(cfg_block, MaxBlock);
      w = clip(cfg_width, MaxWidth);
      h = clip(cfg_height, MaxHeight);
      col = blk_x % MaxWidth;
      if (off_x == 0 && off_y == 0) begin
         red_acc[col] = r; green_acc[col] = g; blue_acc[col] = b;
      end else begin
         red_acc[col] += r; green_acc[col] += g; blue_acc[col] += b;
      end
      sx = (w - (pos_x - off_x) < bs) ? w - (pos_x - off_x) : bs;
      sy = (h - (pos_y - off_y) < bs) ? h - (pos_y - off_y) : bs;
      if (off_x + 1 == sx && off_y + 1 == sy) begin
         cnt = sx * sy;
         m.block_col = blk_x[11:0];
         m.block_row = blk_y[11:0];
         m.span_x = sx[6:0];
         m.span_y = sy[6:0];
         m.red_mean = 8'(red_acc[col] / cnt);
         m.green_mean = 8'(green_acc[col] / cnt);
         m.blue_mean = 8'(blue_acc[col] / cnt);
         m.frame_end = (pos_x + 1 == w && pos_y + 1 == h);
         pending_means.push_back(m);
      end
      pos_x++; off_x++;
      if (off_x >= bs) begin off_x = 0; blk_x++; end
      if (pos_x >= w) begin
         pos_x = 0; off_x = 0; blk_x = 0;
         pos_y++; off_y++;
         if (off_y >= bs) begin off_y = 0; blk_y++; end
         if (pos_y >= h) begin pos_y = 0; off_y = 0; blk_y = 0; end
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_pixel(r, g, b);
      pixels_sent++;
   endtask

   task automatic send_random_pixel();
      logic [7:0] c[3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 7))
            0: c[i] = 8'h00;
            1: c[i] = 8'hFF;
            default: c[i] = 8'($urandom);
         endcase
      end
      send_pixel(c[0], c[1], c[2]);
   endtask

   // hold the sender idle until every expected beat is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_csr(idx, data);
   endtask

   task automatic setup_frame(int bs, int w, int h);
      drain_results();
      write_csr(CSR_BLOCK_SIZE, 13'(bs));
      write_csr(CSR_IMAGE_WIDTH, 13'(w));
      write_csr(CSR_IMAGE_HEIGHT, 13'(h));
   endtask

   task automatic test_reset_defaults();
      for (int i = 0; i < 6; i++) send_random_pixel();
   endtask

   task automatic test_directed_extremes();
      // block 0 acts as 1, width clamps to the maximum, one row
      setup_frame(0, 13'h1FFF, 1);
      send_pixel(8'h00, 8'hFF, 8'h55);
      send_pixel(8'hFF, 8'h00, 8'hAA);
      send_pixel(8'hAA, 8'h55, 8'h00);
      send_pixel(8'h55, 8'hAA, 8'hFF);
      // block above the maximum clamps to 64, frame 3x2 gives one block
      setup_frame(127, 3, 2);
      for (int i = 0; i < 6; i++) send_pixel(8'hFF, 8'hFF, 8'hFF);
      // masked block size 65 clamps to 64
      setup_frame(13'h1FC1, 2, 2);
      send_pixel(8'h01, 8'h02, 8'h03);
      send_pixel(8'h00, 8'h00, 8'h00);
      // spare index leaves the frame position alone
      drain_results();
      write_csr(CSR_SPARE, 13'h1555);
      send_pixel(8'hFE, 8'h7F, 8'h80);
      send_pixel(8'h01, 8'h80, 8'h7F);
      // width and height 0 act as 1
      setup_frame(1, 0, 0);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_pixel(8'hED, 8'hCB, 8'hA9);
      // tall column: height clamps to the maximum
      setup_frame(1, 1, 13'h1FFF);
      for (int i = 0; i < 4; i++) send_random_pixel();
      // block larger than the frame in both directions
      setup_frame(64, 1, 3);
      for (int i = 0; i < 3; i++) send_random_pixel();
   endtask

   task automatic test_random_frames(int target);
      int bs, w, h, n;
      bit paused = 0;
      while (pixels_sent < target) begin
         bs = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
         w = $urandom_range(1, 40);
         h = $urandom_range(1, 200 / w);
         if (h > 20) h = 20;
         setup_frame(bs, w, h);
         steady_send = ($urandom_range(0, 3) == 0);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         for (int i = 0; i < n && pixels_sent < target; i++) begin
            send_random_pixel();
            if (!paused && i == n / 2) begin
               drain_results();
               paused = 1;
            end
         end
         steady_send = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) ready_mode = $urandom_range(0, 2);
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      block_mean_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = pending_means.pop_front();
            if (rsp_block_col != want.block_col)
               report_mismatch("block_col", rsp_block_col, want.block_col);
            if (rsp_block_row != want.block_row)
               report_mismatch("block_row", rsp_block_row, want.block_row);
            if (rsp_span_x != want.span_x) report_mismatch("span_x", rsp_span_x, want.span_x);
            if (rsp_span_y != want.span_y) report_mismatch("span_y", rsp_span_y, want.span_y);
            if (rsp_red_mean != want.red_mean)
               report_mismatch("red_mean", rsp_red_mean, want.red_mean);
            if (rsp_green_mean != want.green_mean)
               report_mismatch("green_mean", rsp_green_mean, want.green_mean);
            if (rsp_blue_mean != want.blue_mean)
               report_mismatch("blue_mean", rsp_blue_mean, want.blue_mean);
            if (rsp_frame_end != want.frame_end)
               report_mismatch("frame_end", rsp_frame_end, want.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("block_average_pixelate regression: fail");
            $finish;
         end
      end
   end

   initial begin
      restart_position();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_extremes();
      test_random_frames(550);
      drain_results();
      if (errors == 0) begin
         $display("block_average_pixelate regression: pass");
      end else begin
         $display("block_average_pixelate regression: fail");
      end
      $finish;
   end
endmodule
